// ===== design/bpr_pkg.sv =====
package bpr_pkg;

  // default geometry and palette size
  localparam int ScreenWidthDef   = 240;
  localparam int ScreenHeightDef  = 160;
  localparam int PaletteEntriesDef = 256;

  // configuration port
  localparam int CfgAddrW = 4;
  localparam int CfgDataW = 32;

  // register index, taken from paddr[3:2]
  localparam logic [1:0] RegForcedBlank = 2'd0;
  localparam logic [1:0] RegVideoMode   = 2'd1;
  localparam logic [1:0] RegPageSelect  = 2'd2;

  localparam logic [2:0]  ModeBitmap8  = 3'd4;
  localparam logic [31:0] OpaqueAlpha  = 32'hFF00_0000;
  localparam logic [16:0] Page1Offset  = 17'h0_A000;
  localparam int          ColorW       = 15;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  palette_slot;
    logic [14:0] palette_color;
    logic [7:0]  pixel_x;
    logic [7:0]  pixel_y;
    logic [7:0]  color_index;
  } pix_req_t;

  typedef struct packed {
    logic [31:0] argb_pixel;
    logic [15:0] pixel_offset;
    logic [16:0] source_offset;
    logic        frame_end;
  } pix_rsp_t;

  typedef struct packed {
    logic       forced_blank;
    logic [2:0] video_mode;
    logic       page_select;
  } cfg_t;

endpackage

// ===== design/bpr_ram.sv =====
module bpr_ram #(
  parameter int Width = 15,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/bpr_cfg_regs.sv =====
module bpr_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bpr_pkg::CfgAddrW-1:0] paddr,
  input  logic [bpr_pkg::CfgDataW-1:0] pwdata,
  output logic [bpr_pkg::CfgDataW-1:0] prdata,
  output logic                         pready,
  output bpr_pkg::cfg_t                cfg_o
);

  bpr_pkg::cfg_t cfg_q, cfg_d;
  logic          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (paddr[3:2])
        bpr_pkg::RegForcedBlank: cfg_d.forced_blank = pwdata[0];
        bpr_pkg::RegVideoMode:   cfg_d.video_mode   = pwdata[2:0];
        bpr_pkg::RegPageSelect:  cfg_d.page_select  = pwdata[0];
        default: ; // no register there
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    prdata = '0;
    case (paddr[3:2])
      bpr_pkg::RegForcedBlank: prdata[0]   = cfg_q.forced_blank;
      bpr_pkg::RegVideoMode:   prdata[2:0] = cfg_q.video_mode;
      bpr_pkg::RegPageSelect:  prdata[0]   = cfg_q.page_select;
      default: prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/bitmap_palette_pixel_render.sv =====
// a pixel is offered once it has passed the stage 1 and output registers
// one item per cycle unless stalled, palette writes and pixels freely mixed
// the palette ram port (one write, one registered read per cycle) sets the rate
// reset: palette valid flags cleared at once, so every entry reads as black;
// configuration registers return to zero, no clearing pass is needed
module bitmap_palette_pixel_render #(
  parameter int SCREEN_WIDTH    = bpr_pkg::ScreenWidthDef,
  parameter int SCREEN_HEIGHT   = bpr_pkg::ScreenHeightDef,
  parameter int PALETTE_ENTRIES = bpr_pkg::PaletteEntriesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // pixel and palette-write items
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  bpr_pkg::pix_req_t            in_item_i,
  // rendered pixels
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output bpr_pkg::pix_rsp_t            out_item_o,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bpr_pkg::CfgAddrW-1:0] paddr,
  input  logic [bpr_pkg::CfgDataW-1:0] pwdata,
  output logic [bpr_pkg::CfgDataW-1:0] prdata,
  output logic                         pready
);

  localparam int AddrW = $clog2(PALETTE_ENTRIES);

  bpr_pkg::cfg_t cfg;

  bpr_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // ---------------------------------------------------------------------------
  // stage 0: accept, palette write or palette read, position arithmetic
  // ---------------------------------------------------------------------------
  logic        in_acc;
  logic        is_pixel;
  logic        slot_ok;
  logic        idx_ok;
  logic        on_screen;
  logic        renders;
  logic        pal_we;
  logic        pal_re;
  logic [31:0] offset_full;
  logic        last_pix;

  logic        s1_valid_q, s1_valid_d;
  logic        s1_move;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign is_pixel = in_item_i.req_type;

  assign slot_ok   = 32'(in_item_i.palette_slot) < 32'(PALETTE_ENTRIES);
  assign idx_ok    = 32'(in_item_i.color_index) < 32'(PALETTE_ENTRIES);
  assign on_screen = (32'(in_item_i.pixel_x) < 32'(SCREEN_WIDTH)) &&
                     (32'(in_item_i.pixel_y) < 32'(SCREEN_HEIGHT));

  // forced blank wins over the mode; other modes drop the pixel
  assign renders = is_pixel && on_screen &&
                   (cfg.forced_blank || (cfg.video_mode == bpr_pkg::ModeBitmap8));

  assign offset_full = 32'(in_item_i.pixel_y) * 32'(SCREEN_WIDTH) +
                       32'(in_item_i.pixel_x);
  assign last_pix    = (32'(in_item_i.pixel_x) == 32'(SCREEN_WIDTH - 1)) &&
                       (32'(in_item_i.pixel_y) == 32'(SCREEN_HEIGHT - 1));

  // writes beyond the palette are dropped
  assign pal_we = in_acc && !is_pixel && slot_ok;
  // read only when a pixel goes into stage 1, so the read data holds while stalled
  assign pal_re = in_acc && renders;

  // palette storage; a write lands before any later item's read, so no bypass
  logic [bpr_pkg::ColorW-1:0] pal_rdata;

  bpr_ram #(
    .Width (bpr_pkg::ColorW),
    .Depth (PALETTE_ENTRIES)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (in_item_i.palette_slot[AddrW-1:0]),
    .wdata_i (in_item_i.palette_color),
    .re_i    (pal_re),
    .raddr_i (in_item_i.color_index[AddrW-1:0]),
    .rdata_o (pal_rdata)
  );

  // per-entry written flags stand in for clearing the ram after reset
  logic [PALETTE_ENTRIES-1:0] pal_vld_q, pal_vld_d;
  logic                       rd_vld_q, rd_vld_d;

  always_comb begin
    pal_vld_d = pal_vld_q;
    if (pal_we) begin
      pal_vld_d[in_item_i.palette_slot[AddrW-1:0]] = 1'b1;
    end
    rd_vld_d = rd_vld_q;
    if (pal_re) begin
      rd_vld_d = pal_vld_q[in_item_i.color_index[AddrW-1:0]] && idx_ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pal_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      pal_vld_q <= pal_vld_d;
      rd_vld_q  <= rd_vld_d;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: palette data arrives, colour expansion and source offset
  // ---------------------------------------------------------------------------
  logic        s1_blank_q;
  logic [16:0] s1_offset_q;
  logic        s1_last_q;

  logic                 out_valid_q, out_valid_d;
  bpr_pkg::pix_rsp_t    out_item_q, out_item_d;

  // stage 1 moves on when the output register is empty or being emptied
  assign s1_move    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_move;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_move) begin
      s1_valid_d = 1'b0;
    end
    if (pal_re) begin
      s1_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pal_re) begin
      s1_blank_q  <= cfg.forced_blank;
      s1_offset_q <= offset_full[16:0];
      s1_last_q   <= last_pix;
    end
  end

  logic [bpr_pkg::ColorW-1:0] bgr;
  logic [16:0]                page_base;

  assign bgr       = rd_vld_q ? pal_rdata : '0;
  assign page_base = cfg.page_select ? bpr_pkg::Page1Offset : 17'd0;

  always_comb begin
    out_item_d = out_item_q;
    if (s1_move) begin
      out_item_d.pixel_offset = s1_offset_q[15:0];
      out_item_d.frame_end    = s1_last_q;
      if (s1_blank_q) begin
        // no video memory is read while blanked
        out_item_d.argb_pixel    = bpr_pkg::OpaqueAlpha;
        out_item_d.source_offset = 17'd0;
      end else begin
        out_item_d.argb_pixel    = bpr_pkg::OpaqueAlpha |
                                   {8'h00, bgr[4:0], 3'b000, bgr[9:5], 3'b000,
                                    bgr[14:10], 3'b000};
        out_item_d.source_offset = page_base + s1_offset_q;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (s1_move) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== bench/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // geometry as built into the block under test
  localparam int ScreenW    = bpr_pkg::ScreenWidthDef;
  localparam int ScreenH    = bpr_pkg::ScreenHeightDef;
  localparam int PaletteN   = bpr_pkg::PaletteEntriesDef;
  // pixels pass the stage 1 and output registers, so this covers the pipe with margin
  localparam int DrainCycles = 6;
  // cycles with no item moving on either side before the run is declared hung
  localparam int QuietLimit  = 2000;
  // random part: segments of items, each with its own register setting
  localparam int Segments    = 13;
  localparam int SegItems    = 150;
  localparam int ReportMax   = 10;

  typedef enum logic {RowConfig, RowItem} row_kind_e;

  // one line of the directed table: a register write or an item,
  // optionally with the rendered pixel typed in by hand
  typedef struct packed {
    row_kind_e          kind;
    logic [1:0]         reg_idx;
    logic [31:0]        value;
    bpr_pkg::pix_req_t  item;
    logic               typed;
    bpr_pkg::pix_rsp_t  want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // item ports
  logic              in_valid = 1'b0;
  logic              in_stall;
  bpr_pkg::pix_req_t in_item = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  bpr_pkg::pix_rsp_t out_item;

  // register port
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [bpr_pkg::CfgAddrW-1:0] paddr = '0;
  logic [bpr_pkg::CfgDataW-1:0] pwdata = '0;
  logic [bpr_pkg::CfgDataW-1:0] prdata;
  logic                         pready;

  // shadow of the block's state, kept in step with accepted items
  logic [bpr_pkg::ColorW-1:0] palette_shadow [PaletteN];
  bpr_pkg::cfg_t              cfg_shadow;
  bpr_pkg::pix_rsp_t          pending_pixels [$];

  // hand-typed pixel for the item currently on offer
  logic              row_typed = 1'b0;
  bpr_pkg::pix_rsp_t row_want = '0;

  int sender_idle_pct = 21;
  int receiver_idle_pct = 82;
  int mismatches = 0;
  int quiet_cycles = 0;

  row_t directed_rows [$];

  bitmap_palette_pixel_render dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver back-pressure, redrawn every cycle
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
  end

  // expected pixel for one item under the current palette and registers;
  // returns 0 when the item renders nothing
  function automatic logic predict_pixel(input bpr_pkg::pix_req_t req,
                                         output bpr_pkg::pix_rsp_t rsp);
    logic [bpr_pkg::ColorW-1:0] bgr;
    logic [16:0]                base;
    rsp = '0;
    // off-screen positions never render
    if (req.pixel_x >= ScreenW || req.pixel_y >= ScreenH) return 1'b0;
    rsp.pixel_offset = 16'(req.pixel_y * ScreenW + req.pixel_x);
    rsp.frame_end    = (req.pixel_x == ScreenW - 1) && (req.pixel_y == ScreenH - 1);
    // forced blank wins over any mode and reads no video memory
    if (cfg_shadow.forced_blank) begin
      rsp.argb_pixel    = bpr_pkg::OpaqueAlpha;
      rsp.source_offset = '0;
      return 1'b1;
    end
    if (cfg_shadow.video_mode != bpr_pkg::ModeBitmap8) return 1'b0;
    // an index past the palette reads as black
    bgr = (req.color_index < PaletteN) ? palette_shadow[req.color_index] : '0;
    rsp.argb_pixel = {bpr_pkg::OpaqueAlpha[31:24], bgr[4:0], 3'b000, bgr[9:5], 3'b000,
                      bgr[14:10], 3'b000};
    base = cfg_shadow.page_select ? bpr_pkg::Page1Offset : 17'd0;
    rsp.source_offset = base + 17'(rsp.pixel_offset);
    return 1'b1;
  endfunction

  task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
    mismatches++;
    if (mismatches <= ReportMax)
      $display("%0t mismatch: %s expected %h got %h", $realtime, what, want, got);
  endtask

  // scoreboard and watchdog; outputs are checked before new items are
  // predicted so that nothing hangs on event order within the edge
  always @(posedge clk) begin : monitor
    bpr_pkg::pix_rsp_t want;
    logic              moved;
    if (rst_n) begin
      moved = psel;
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (pending_pixels.size() == 0) begin
          report("pixel with nothing pending, argb", '0, out_item.argb_pixel);
        end else begin
          want = pending_pixels.pop_front();
          if (out_item.argb_pixel !== want.argb_pixel)
            report("argb_pixel", want.argb_pixel, out_item.argb_pixel);
          if (out_item.pixel_offset !== want.pixel_offset)
            report("pixel_offset", 32'(want.pixel_offset), 32'(out_item.pixel_offset));
          if (out_item.source_offset !== want.source_offset)
            report("source_offset", 32'(want.source_offset), 32'(out_item.source_offset));
          if (out_item.frame_end !== want.frame_end)
            report("frame_end", 32'(want.frame_end), 32'(out_item.frame_end));
        end
      end
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        if (!in_item.req_type) begin
          // palette write: slots past the palette are dropped
          if (in_item.palette_slot < PaletteN)
            palette_shadow[in_item.palette_slot] = in_item.palette_color;
        end else if (predict_pixel(in_item, want)) begin
          pending_pixels.push_back(row_typed ? row_want : want);
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t watchdog: no item moved for %0d cycles", $realtime, QuietLimit);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // offer one item, with random idle cycles ahead of it, and hold it until taken
  task automatic send_item(input bpr_pkg::pix_req_t item, input logic typed,
                           input bpr_pkg::pix_rsp_t want);
    @(negedge clk);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_item   <= item;
    row_typed = typed;
    row_want  = want;
    do @(posedge clk); while (in_stall);
  endtask

  // stop offering items and let every pending pixel come out
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // register write followed by a read-back of the same register
  task automatic cfg_write(input logic [1:0] reg_idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (reg_idx)
      bpr_pkg::RegForcedBlank: cfg_shadow.forced_blank = value[0];
      bpr_pkg::RegVideoMode:   cfg_shadow.video_mode   = value[2:0];
      bpr_pkg::RegPageSelect:  cfg_shadow.page_select  = value[0];
      default: ;
    endcase
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== value) report("register read-back", value, prdata);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // table helpers
  function automatic row_t row_cfg(input logic [1:0] reg_idx, input logic [31:0] value);
    row_t r = '0;
    r.kind    = RowConfig;
    r.reg_idx = reg_idx;
    r.value   = value;
    return r;
  endfunction

  function automatic row_t row_pal(input logic [7:0] slot, input logic [14:0] colour);
    row_t r = '0;
    r.kind               = RowItem;
    r.item.req_type      = 1'b0;
    r.item.palette_slot  = slot;
    r.item.palette_color = colour;
    return r;
  endfunction

  function automatic row_t row_pix(input logic [7:0] x, input logic [7:0] y,
                                   input logic [7:0] idx);
    row_t r = '0;
    r.kind             = RowItem;
    r.item.req_type    = 1'b1;
    r.item.pixel_x     = x;
    r.item.pixel_y     = y;
    r.item.color_index = idx;
    return r;
  endfunction

  function automatic row_t row_pix_want(input logic [7:0] x, input logic [7:0] y,
                                        input logic [7:0] idx, input logic [31:0] argb,
                                        input logic [15:0] offset, input logic [16:0] src,
                                        input logic last);
    row_t r = row_pix(x, y, idx);
    r.typed = 1'b1;
    r.want  = '{argb_pixel: argb, pixel_offset: offset, source_offset: src,
                frame_end: last};
    return r;
  endfunction

  // random item: mostly on-screen pixels, a share of palette writes,
  // the odd off-screen position and a few hits on the frame corner
  function automatic bpr_pkg::pix_req_t random_item();
    bpr_pkg::pix_req_t req;
    logic [63:0]       noise;
    int                roll;
    noise = {$urandom, $urandom};
    req   = noise[$bits(bpr_pkg::pix_req_t)-1:0];
    req.req_type = ($urandom_range(0, 99) >= 30);
    if (req.req_type) begin
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        req.pixel_x = 8'(ScreenW - 1);
        req.pixel_y = 8'(ScreenH - 1);
      end else if (roll >= 15) begin
        req.pixel_x = 8'($urandom_range(0, ScreenW - 1));
        req.pixel_y = 8'($urandom_range(0, ScreenH - 1));
      end
      // otherwise keep the full-range noise, often off screen
    end
    return req;
  endfunction

  initial begin
    foreach (palette_shadow[i]) palette_shadow[i] = '0;
    cfg_shadow = '0;

    // directed table
    // mode 0 after reset: nothing rendered
    directed_rows.push_back(row_pix(8'd3, 8'd4, 8'd0));
    directed_rows.push_back(row_cfg(bpr_pkg::RegVideoMode, 32'(bpr_pkg::ModeBitmap8)));
    // palette is black after reset, first and last pixel of the frame
    directed_rows.push_back(row_pix_want(8'd0, 8'd0, 8'd0, 32'hFF00_0000, 16'd0, 17'd0, 1'b0));
    directed_rows.push_back(row_pix_want(8'd239, 8'd159, 8'd255, 32'hFF00_0000,
                                         16'd38399, 17'd38399, 1'b1));
    // white, full red, full green, full blue
    directed_rows.push_back(row_pal(8'd0, 15'h7FFF));
    directed_rows.push_back(row_pal(8'd255, 15'h001F));
    directed_rows.push_back(row_pal(8'd1, 15'h03E0));
    directed_rows.push_back(row_pal(8'd2, 15'h7C00));
    directed_rows.push_back(row_pix_want(8'd0, 8'd0, 8'd0, 32'hFFF8_F8F8, 16'd0, 17'd0, 1'b0));
    directed_rows.push_back(row_pix_want(8'd239, 8'd0, 8'd255, 32'hFFF8_0000,
                                         16'd239, 17'd239, 1'b0));
    directed_rows.push_back(row_pix_want(8'd0, 8'd159, 8'd1, 32'hFF00_F800,
                                         16'd38160, 17'd38160, 1'b0));
    directed_rows.push_back(row_pix_want(8'd239, 8'd159, 8'd2, 32'hFF00_00F8,
                                         16'd38399, 17'd38399, 1'b1));
    // palette write straight followed by a read of the same entry
    directed_rows.push_back(row_pal(8'd0, 15'h5555));
    directed_rows.push_back(row_pix(8'd10, 8'd1, 8'd0));
    // off-screen positions
    directed_rows.push_back(row_pix(8'd240, 8'd0, 8'd1));
    directed_rows.push_back(row_pix(8'd255, 8'd255, 8'd1));
    directed_rows.push_back(row_pix(8'd0, 8'd160, 8'd1));
    // second page
    directed_rows.push_back(row_cfg(bpr_pkg::RegPageSelect, 32'd1));
    directed_rows.push_back(row_pix_want(8'd0, 8'd0, 8'd255, 32'hFFF8_0000,
                                         16'd0, 17'h0_A000, 1'b0));
    directed_rows.push_back(row_pix_want(8'd239, 8'd159, 8'd2, 32'hFF00_00F8,
                                         16'd38399, 17'd79359, 1'b1));
    // forced blank: black, no source read
    directed_rows.push_back(row_cfg(bpr_pkg::RegForcedBlank, 32'd1));
    directed_rows.push_back(row_pix_want(8'd100, 8'd50, 8'd255, 32'hFF00_0000,
                                         16'd12100, 17'd0, 1'b0));
    directed_rows.push_back(row_pix_want(8'd239, 8'd159, 8'd0, 32'hFF00_0000,
                                         16'd38399, 17'd0, 1'b1));
    // forced blank still renders in a non-bitmap mode
    directed_rows.push_back(row_cfg(bpr_pkg::RegVideoMode, 32'd7));
    directed_rows.push_back(row_pix_want(8'd5, 8'd5, 8'd0, 32'hFF00_0000,
                                         16'd1205, 17'd0, 1'b0));
    // blank off in mode 7: pixels vanish, palette writes still land
    directed_rows.push_back(row_cfg(bpr_pkg::RegForcedBlank, 32'd0));
    directed_rows.push_back(row_pix(8'd5, 8'd5, 8'd0));
    directed_rows.push_back(row_pal(8'd3, 15'h1234));

    // single reset at the start
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == RowConfig) begin
        drain();
        cfg_write(directed_rows[i].reg_idx, directed_rows[i].value);
      end else begin
        send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // random part, fresh register setting per segment
    for (int seg = 0; seg < Segments; seg++) begin
      // idling phases: sender light/receiver heavy, swapped, then none
      if (seg == 5) begin
        sender_idle_pct   = 82;
        receiver_idle_pct = 21;
      end
      if (seg == 9) begin
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
      end
      drain();
      cfg_write(bpr_pkg::RegForcedBlank, 32'($urandom_range(0, 99) < 15));
      cfg_write(bpr_pkg::RegVideoMode,
                ($urandom_range(0, 99) < 75) ? 32'(bpr_pkg::ModeBitmap8)
                                             : 32'($urandom_range(0, 7)));
      cfg_write(bpr_pkg::RegPageSelect, 32'($urandom_range(0, 1)));
      repeat (SegItems) send_item(random_item(), 1'b0, '0);
    end

    drain();
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/bpr_pkg.sv
design/bpr_ram.sv
design/bpr_cfg_regs.sv
design/bitmap_palette_pixel_render.sv
bench/testbench.sv
